[sv/b64e_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg
// shared types, constants and the alphabet lookup for the base64 encoder
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [6:0] PAD_CHAR = 7'h3D;   // '='

    localparam logic [1:0] HAVE_ONE   = 2'd1;
    localparam logic [1:0] HAVE_TWO   = 2'd2;
    localparam logic [1:0] HAVE_THREE = 2'd3;

    localparam logic [1:0] CHAR_IDX_LAST = 2'd3;

    // one complete or closing group of up to three bytes
    typedef struct packed {
        logic [23:0] bytes;     // first byte in the top bits, missing bytes zero
        logic [1:0]  have;      // number of real bytes, 1..3
        logic        ends;      // group closes the field
    } group_t;

    // push side of the group queue
    typedef struct packed {
        logic   valid;
        group_t grp;
    } group_push_t;

    // standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [6:0] b64_char(input logic [5:0] sextet);
        logic [6:0] s;
        logic [6:0] c;
        begin
            s = {1'b0, sextet};
            if (s < 7'd26)
            begin
                c = 7'h41 + s;
            end
            else if (s < 7'd52)
            begin
                c = 7'h61 + (s - 7'd26);
            end
            else if (s < 7'd62)
            begin
                c = 7'h30 + (s - 7'd52);
            end
            else if (s == 7'd62)
            begin
                c = 7'h2B;
            end
            else
            begin
                c = 7'h2F;
            end
            return c;
        end
    endfunction

endpackage

[sv/b64e_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front
// gathers input bytes into groups of three and pushes each closed group
// ----------------------------------------------------------------------------
module b64e_front
    import b64e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_end,
    output group_push_t push,
    input  logic        push_ready
);

    logic [15:0] held_reg, held_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        accept;
    logic        closes;
    group_t      grp;

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;
    assign closes   = in_end || (cnt_reg >= HAVE_TWO);

    always_comb
    begin
        grp.ends = in_end;
        case (cnt_reg)
            2'd0:
            begin
                grp.bytes = {in_byte, 16'h0000};
                grp.have  = HAVE_ONE;
            end
            2'd1:
            begin
                grp.bytes = {held_reg[15:8], in_byte, 8'h00};
                grp.have  = HAVE_TWO;
            end
            default:
            begin
                grp.bytes = {held_reg, in_byte};
                grp.have  = HAVE_THREE;
            end
        endcase
    end

    assign push.valid = accept && closes;
    assign push.grp   = grp;

    always_comb
    begin
        held_next = held_reg;
        cnt_next  = cnt_reg;
        if (accept)
        begin
            if (closes)
            begin
                held_next = 16'h0000;
                cnt_next  = 2'd0;
            end
            else if (cnt_reg == 2'd0)
            begin
                held_next = {in_byte, 8'h00};
                cnt_next  = 2'd1;
            end
            else
            begin
                held_next = {held_reg[15:8], in_byte};
                cnt_next  = 2'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 16'h0000;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            held_reg <= held_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

[sv/b64e_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_queue
// short group queue between the byte gatherer and the character serializer
// ----------------------------------------------------------------------------
module b64e_queue
    import b64e_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  group_push_t push,
    output logic        push_ready,
    output logic        head_valid,
    output group_t      head,
    input  logic        pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    group_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_FULL);
    assign head_valid = (cnt_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.grp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[sv/b64e_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back
// turns each queued group into four characters, one per beat
// ----------------------------------------------------------------------------
module b64e_back
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  group_t     head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] out_char,
    output logic       out_group_last,
    output logic       out_done
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [6:0] char_reg, char_next;
    logic       glast_reg, glast_next;
    logic       done_reg, done_next;
    logic       load;
    logic [5:0] sextet;
    logic       is_pad;

    assign load = head_valid && (!valid_reg || out_ready);
    assign pop  = load && (idx_reg == CHAR_IDX_LAST);

    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = head.bytes[23:18];
            2'd1:    sextet = head.bytes[17:12];
            2'd2:    sextet = head.bytes[11:6];
            default: sextet = head.bytes[5:0];
        endcase
    end

    // padding where the group ran short of bytes
    assign is_pad = ((idx_reg == 2'd2) && (head.have < HAVE_TWO))
                 || ((idx_reg == CHAR_IDX_LAST) && (head.have < HAVE_THREE));

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        glast_next = glast_reg;
        done_next  = done_reg;
        if (load)
        begin
            idx_next   = idx_reg + 1'b1;
            valid_next = 1'b1;
            char_next  = is_pad ? PAD_CHAR : b64_char(sextet);
            glast_next = (idx_reg == CHAR_IDX_LAST);
            done_next  = (idx_reg == CHAR_IDX_LAST) && head.ends;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg  <= char_next;
        glast_reg <= glast_next;
        done_reg  <= done_next;
    end

    assign out_valid      = valid_reg;
    assign out_char       = char_reg;
    assign out_group_last = glast_reg;
    assign out_done       = done_reg;

endmodule

[sv/base64_stream_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder
// standard-alphabet base64 encoder over a byte stream, one character per beat
// ----------------------------------------------------------------------------
// Bytes enter one per beat on the s_ side, with s_tlast on the last byte of a
// field. Every third byte closes a group; a field that ends mid-group is
// zero-filled and padded with '=' to four characters. An empty field produces
// nothing. Characters leave one per beat on the m_ side: m_tuser marks the
// fourth character of each group and m_tlast the final character of a field.
// The input side takes a byte every cycle while the group queue has room; the
// output register issues one character per cycle while m_tready is high and a
// group is queued, so the sustained rate is four output beats per three input
// bytes over full groups, set by the single-character output register. A byte
// that closes a group is first written into the group queue, and its first
// character is then loaded into the output register. The queue between
// gatherer and serializer holds QUEUE_DEPTH groups, so either side can stall
// without blocking the other until the queue fills or runs empty.
// ----------------------------------------------------------------------------
module base64_stream_encoder
    import b64e_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    // input beats
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // field_end
    // output beats
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
    output logic       m_tuser,   // group_last
    output logic       m_tlast    // field_done
);

    group_push_t grp_push;
    logic        grp_push_ready;
    logic        head_valid;
    group_t      head;
    logic        head_pop;
    logic [6:0]  out_char;

    // front: gather bytes into groups
    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_end     (s_tlast),
        .push       (grp_push),
        .push_ready (grp_push_ready)
    );

    // decoupling queue of closed groups
    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (grp_push),
        .push_ready (grp_push_ready),
        .head_valid (head_valid),
        .head       (head),
        .pop        (head_pop)
    );

    // back: serialize groups into characters
    b64e_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head           (head),
        .pop            (head_pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_char       (out_char),
        .out_group_last (m_tuser),
        .out_done       (m_tlast)
    );

    assign m_tdata = {1'b0, out_char};

    // the final character of a field is always the last of its group
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser)
    else $error("field end outside group end");

    // a group is only pushed when the queue has room
    assert property (@(posedge clk) disable iff (!rst_n)
        grp_push.valid |-> grp_push_ready)
    else $error("group pushed into full queue");

    // a group leaves the queue when its fourth character is loaded into the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |=> m_tvalid && m_tuser)
    else $error("group popped without its fourth character");

    // padding shown first after an idle output is always the fourth character of a group
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) && (m_tdata[6:0] == PAD_CHAR) |-> m_tuser || $past(m_tvalid))
    else $error("padding at the start of a group");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the streaming base64 encoder
// ----------------------------------------------------------------------------
// Fields of raw bytes are fed on the s_ side. Each accepted byte is run
// through a local base64 encoder model, and the characters it implies are
// queued. Every m_ beat is checked against the oldest queued character:
// character, group-last flag and field-done flag. The run starts with
// hand-picked fields and then moves on to random fields. It goes through
// three idling phases and one long output hold-off that backs the encoder
// up into its input.
// ----------------------------------------------------------------------------
module tb;
    import b64e_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int LIMIT_CYCLES = 200000;
    localparam int TAIL_CYCLES  = 20;
    localparam int HOLD_CYCLES  = 48;
    localparam int RAND_BYTES   = 136;
    localparam int N_DIRECTED   = 25;

    // one raw byte as offered to the encoder
    typedef struct packed {
        logic       field_end;
        logic [7:0] data;
    } raw_byte_t;

    // one encoded character as it should leave the encoder
    typedef struct packed {
        logic [6:0] ch;
        logic       grp_last;
        logic       done;
    } enc_char_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;    // [7:0] data_byte
    logic       s_tlast = 1'b0;     // field_end
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [6:0] out_char, [7] zero
    logic       m_tuser;            // group_last
    logic       m_tlast;            // field_done

    // standard alphabet, index 0 in the top byte
    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // hand-picked fields, {field_end, byte}
    localparam logic [8:0] DIRECTED [0:N_DIRECTED-1] = '{
        9'h100,                                 // one zero byte -> "AA=="
        9'h1FF,                                 // one 0xff byte -> "/w=="
        9'h0FF, 9'h1FF,                         // two bytes -> three chars and "="
        9'h0FB, 9'h0EF, 9'h1BE,                 // full group at the end -> "++++"
        9'h0FF, 9'h0FF, 9'h1FF,                 // all ones -> "////"
        9'h000, 9'h010, 9'h083, 9'h180,         // group, then one byte closes
        9'h04D, 9'h061, 9'h06E, 9'h0FE, 9'h101, // group, then two bytes close
        9'h000, 9'h000, 9'h000,                 // two full groups, the second
        9'h0FF, 9'h0FF, 9'h1FF                  // closing the field
    };

    // stimulus and expectations
    raw_byte_t byte_backlog [$];
    enc_char_t pending_chars [$];

    // encoder model state
    logic [15:0] held_bytes;
    logic [1:0]  held_cnt;

    // run control shared between processes
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    bit  beat_taken = 1'b0;

    int  err_cnt = 0;
    int  cycle_cnt = 0;
    int  bytes_in = 0;
    int  chars_out = 0;
    int  fields_sent = 0;

    base64_stream_encoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #CLK_HALF clk = ~clk;

    function automatic logic [6:0] sextet_char(input logic [5:0] idx);
        logic [7:0] c;
        begin
            c = ALPHABET[8*(63 - idx) +: 8];
            return c[6:0];
        end
    endfunction

    // model one accepted byte; a closing byte queues four characters
    task automatic encode_byte(input logic [7:0] b, input logic last);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] cnt;
        enc_char_t  c;
        begin
            cnt = (held_cnt > 2'd2) ? 2'd2 : held_cnt;
            if (cnt < 2'd2 && !last)
            begin
                // still gathering the group
                if (cnt == 2'd0)
                begin
                    held_bytes = {b, 8'h00};
                end
                else
                begin
                    held_bytes[7:0] = b;
                end
                held_cnt = cnt + 2'd1;
            end
            else
            begin
                // group is full or the field ends: missing bytes are zero
                b0 = held_bytes[15:8];
                b1 = held_bytes[7:0];
                b2 = 8'h00;
                if (cnt == 2'd0)
                begin
                    b0 = b;
                    b1 = 8'h00;
                end
                else if (cnt == 2'd1)
                begin
                    b1 = b;
                end
                else
                begin
                    b2 = b;
                end
                c = '{sextet_char(b0[7:2]), 1'b0, 1'b0};
                pending_chars.push_back(c);
                c = '{sextet_char({b0[1:0], b1[7:4]}), 1'b0, 1'b0};
                pending_chars.push_back(c);
                c.ch = (cnt >= 2'd1) ? sextet_char({b1[3:0], b2[7:6]}) : PAD_CHAR;
                pending_chars.push_back(c);
                c.ch = (cnt >= 2'd2) ? sextet_char(b2[5:0]) : PAD_CHAR;
                c.grp_last = 1'b1;
                c.done = last;
                pending_chars.push_back(c);
                held_bytes = 16'h0000;
                held_cnt = 2'd0;
            end
        end
    endtask

    // random field: mostly short, sometimes long, bytes biased to the extremes
    task automatic add_random_field(output int len);
        int         k;
        int         pick;
        raw_byte_t  rb;
        begin
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 7)
                                               : $urandom_range(8, 20);
            for (k = 0; k < len; k++)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    rb.data = 8'h00;
                end
                else if (pick == 1)
                begin
                    rb.data = 8'hFF;
                end
                else
                begin
                    rb.data = 8'($urandom_range(0, 255));
                end
                rb.field_end = (k == len - 1);
                byte_backlog.push_back(rb);
            end
            fields_sent++;
        end
    endtask

    task automatic wait_drained();
        begin
            while (byte_backlog.size() != 0 || s_tvalid || pending_chars.size() != 0)
            begin
                @(posedge clk);
            end
        end
    endtask

    // sender: next byte goes out at the falling edge once the last one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || beat_taken))
        begin
            if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                raw_byte_t rb;
                rb = byte_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= rb.data;
                s_tlast  <= rb.field_end;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
        beat_taken = 1'b0;
    end

    // receiver: random backpressure, plus the long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor: model accepted input beats, check output beats
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            encode_byte(s_tdata, s_tlast);
            beat_taken = 1'b1;
            bytes_in++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            enc_char_t want;
            chars_out++;
            if (pending_chars.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected beat, got char %h user %b last %b",
                         $time, m_tdata, m_tuser, m_tlast);
            end
            else
            begin
                want = pending_chars.pop_front();
                if (m_tdata !== {1'b0, want.ch} || m_tuser !== want.grp_last
                    || m_tlast !== want.done)
                begin
                    err_cnt++;
                    $display({"%0t: mismatch, expected char %h user %b last %b, ",
                              "got char %h user %b last %b"},
                             $time, {1'b0, want.ch}, want.grp_last, want.done,
                             m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d characters outstanding", $time,
                     pending_chars.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int        k;
        int        len;
        int        rand_sent;
        int        phase;
        raw_byte_t rb;

        held_bytes = 16'h0000;
        held_cnt = 2'd0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        rand_sent = 0;
        for (phase = 0; phase < 3; phase++)
        begin
            // phase 0: light sender gaps, heavy backpressure; phase 1: reversed;
            // phase 2: full rate after a long output hold-off
            send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 69 : 0;
            recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 11 : 0;
            if (phase == 0)
            begin
                for (k = 0; k < N_DIRECTED; k++)
                begin
                    rb.field_end = DIRECTED[k][8];
                    rb.data = DIRECTED[k][7:0];
                    byte_backlog.push_back(rb);
                    if (rb.field_end)
                    begin
                        fields_sent++;
                    end
                end
            end
            else if (phase == 2)
            begin
                @(posedge clk);
                hold_req = 1'b1;
            end
            while (rand_sent < (RAND_BYTES * (phase + 1)) / 3)
            begin
                add_random_field(len);
                rand_sent += len;
            end
            // sender pauses here until every queued character has come out
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d fields, %0d bytes in, %0d characters out", fields_sent,
                 bytes_in, chars_out);
        $display("idling phases: sender-light, receiver-light, none; one %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (err_cnt == 0 && pending_chars.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("%0d errors, %0d characters never seen", err_cnt, pending_chars.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
